// File: hdl/tcwc_pkg.sv
// Package for the TCP congestion window controller: item types, command and
// register codes, field widths and the 22-bit saturation helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tcwc_pkg;

  localparam int SEQ_W   = 32;
  localparam int RTT_W   = 20;
  localparam int Q_W     = 22;
  localparam int CNT_W   = 7;
  localparam int CFG_W   = 20;
  localparam int CFG_IDX_W = 2;
  localparam int SSTH_W  = 7;
  localparam int FINR_W  = 9;
  localparam int DUP_W   = 3;

  localparam logic [1:0] CMD_SEND    = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_RTT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SSTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIN_ROUNDS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUP_LIMIT = 2'd3;

  localparam logic [Q_W-1:0] MASK22 = {Q_W{1'b1}};

  localparam logic [RTT_W-1:0]  RST_INIT_RTT  = 20'd1920;
  localparam logic [SSTH_W-1:0] RST_INIT_SSTH = 7'd64;
  localparam logic [FINR_W-1:0] RST_FIN_ROUNDS = 9'd500;
  localparam logic [DUP_W-1:0]  RST_DUP_LIMIT = 3'd3;

  typedef struct packed {
    logic [1:0]       command;
    logic [SEQ_W-1:0] new_seqno;
    logic [SEQ_W-1:0] ack_number;
    logic             final_ack;
    logic [RTT_W-1:0] rtt_sample_q4;
  } cmd_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] cwnd_size;
    logic [Q_W-1:0]   ssthresh_q16;
    logic [CNT_W-1:0] in_flight;
    logic [SEQ_W-1:0] send_seqno;
    logic             from_cache;
    logic             send_refused;
    logic [CNT_W-1:0] cache_count;
    logic             retransmit;
    logic [SEQ_W-1:0] retransmit_seqno;
    logic             timer_restart;
    logic [Q_W-1:0]   timeout_q4;
    logic             finished;
  } res_item_t;

  function automatic logic [Q_W-1:0] sat22(input logic [24:0] v);
    logic [Q_W-1:0] r;
    r = (v > 25'(MASK22)) ? MASK22 : v[Q_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/tcwc_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on tcwc_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tcwc_cmd_if;
  import tcwc_pkg::*;
  logic      valid;
  logic      ready;
  cmd_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcwc_res_if;
  import tcwc_pkg::*;
  logic      valid;
  logic      ready;
  res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/tcp_congestion_window_controller.sv
// Top level of the TCP congestion window controller: sequencer, slot table,
// resend cache, bit-serial divider and RTT estimator. Depends on tcwc_pkg, tcwc_if.
//
// One item is taken at a time; the block is ready again once the previous
// result has been registered. A send scans for a free slot inside the window;
// one served from the cache then shifts the cache down one entry at a time, a
// read and then a write through its single memory port. A new ack first updates
// the RTT estimates; every ack walks the slots inside the window and removes each
// acked segment, running the bit-serial divider for each one removed in
// congestion avoidance. A loss sorts the slot table by repeated minimum search
// over the single slot read port, then moves each segment after the first
// inside the window into the sorted cache with a linear scan and a shift of the
// entries above it. Valid bits reset at once; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module tcp_congestion_window_controller #(
  parameter int SLOTS       = 64,
  parameter int CACHE_SLOTS = 64,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  tcwc_cmd_if.sink                           cmd,
  tcwc_res_if.source                         res,
  input  wire logic                          cfg_we,
  input  wire logic [tcwc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tcwc_pkg::CFG_W-1:0]    cfg_data
);
  import tcwc_pkg::*;

  localparam int WIN_W = $clog2(SLOTS + 1);
  localparam int SIW   = $clog2(SLOTS);
  localparam int CNW   = $clog2(CACHE_SLOTS + 1);
  localparam int CIW   = $clog2(CACHE_SLOTS);
  localparam int FW    = FRAC_BITS + 1;
  localparam int DW    = WIN_W + FRAC_BITS + 1;
  localparam int CWA   = ((WIN_W > SSTH_W) ? WIN_W : SSTH_W) + FRAC_BITS + 2;
  localparam int CW    = (CWA > 23) ? CWA : 23;
  localparam int DCW   = $clog2(2 * FRAC_BITS + 1);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(2 * FRAC_BITS);
  localparam logic [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SCAN    = 5'd1;
  localparam logic [4:0] S_SEND    = 5'd2;
  localparam logic [4:0] S_POPWR   = 5'd3;
  localparam logic [4:0] S_SHRD    = 5'd4;
  localparam logic [4:0] S_SHWR    = 5'd5;
  localparam logic [4:0] S_EST     = 5'd6;
  localparam logic [4:0] S_DEV     = 5'd7;
  localparam logic [4:0] S_RCHK    = 5'd8;
  localparam logic [4:0] S_RCMP    = 5'd9;
  localparam logic [4:0] S_GROW    = 5'd10;
  localparam logic [4:0] S_DIV     = 5'd11;
  localparam logic [4:0] S_GFIN    = 5'd12;
  localparam logic [4:0] S_POSTACK = 5'd13;
  localparam logic [4:0] S_LSTART  = 5'd14;
  localparam logic [4:0] S_SRT     = 5'd15;
  localparam logic [4:0] S_SRTCMP  = 5'd16;
  localparam logic [4:0] S_SRTEND  = 5'd17;
  localparam logic [4:0] S_WBCHK   = 5'd18;
  localparam logic [4:0] S_WBUSE   = 5'd19;
  localparam logic [4:0] S_CSCAN   = 5'd20;
  localparam logic [4:0] S_CCMP    = 5'd21;
  localparam logic [4:0] S_CSHRD   = 5'd22;
  localparam logic [4:0] S_CSHWR   = 5'd23;
  localparam logic [4:0] S_LEND    = 5'd24;
  localparam logic [4:0] S_FIN     = 5'd25;

  // configuration
  logic [RTT_W-1:0]  cfg_rtt;
  logic [SSTH_W-1:0] cfg_ssth;
  logic [FINR_W-1:0] cfg_fin;
  logic [DUP_W-1:0]  cfg_dup;

  // control state
  logic [4:0]         state;
  logic [SLOTS-1:0]   slot_valid;
  logic [CNW-1:0]     cnt;
  logic [WIN_W-1:0]   window;
  logic [FW-1:0]      frac;
  // wide enough for the unsaturated threshold loaded at reset
  logic [CW-1:0]      thr;
  logic [WIN_W-1:0]   outstanding;
  logic [SEQ_W-1:0]   last_ack;
  logic [DUP_W-1:0]   dup_count;
  logic               fresh;
  logic [FINR_W-1:0]  idle_rounds;
  logic [Q_W-1:0]     est;
  logic [Q_W-1:0]     dev;
  logic               res_valid;

  // working registers
  logic [1:0]         c_cmd;
  logic [SEQ_W-1:0]   c_seq;
  logic [SEQ_W-1:0]   c_ack;
  logic               c_fin;
  logic [RTT_W-1:0]   c_smp;
  logic               c_newer;
  logic [WIN_W-1:0]   i;
  logic [WIN_W-1:0]   j;
  logic [WIN_W-1:0]   n_sorted;
  logic [CNW-1:0]     k;
  logic [CNW-1:0]     m;
  logic [SEQ_W-1:0]   mn;
  logic [SEQ_W-1:0]   last_v;
  logic               have_min;
  logic               have_last;
  logic [DW-1:0]      den;
  logic [DW-1:0]      rem;
  logic [FRAC_BITS:0] q;
  logic [DCW-1:0]     dcnt;
  logic [SEQ_W-1:0]   slot_rd;
  logic [SEQ_W-1:0]   cache_rd;
  logic [SEQ_W-1:0]   tmp_rd;
  res_item_t          o;
  res_item_t          res_q;

  logic [SEQ_W-1:0] slot_mem  [SLOTS];
  logic [SEQ_W-1:0] tmp_mem   [SLOTS];
  logic [SEQ_W-1:0] cache_mem [CACHE_SLOTS];

  // datapath
  logic [CW-1:0]        w_ext;
  logic [CW-1:0]        wf_sum;
  logic [CW-1:0]        loss_half;
  logic [CW-1:0]        ssth_ext;
  logic [25:0]          esum;
  logic [Q_W-1:0]       est_new;
  logic [Q_W-1:0]       smp22;
  logic [Q_W-1:0]       diff;
  logic [24:0]          dsum;
  logic [Q_W-1:0]       dev_new;
  logic [Q_W-1:0]       tmo_short;
  logic [Q_W-1:0]       tmo_long;
  logic [Q_W-1:0]       tmo_dev;
  logic [DW:0]          rem_sh;
  logic [FRAC_BITS+1:0] fsum;
  logic [DUP_W-1:0]     dup_inc;
  logic [CNW-1:0]       k_inc;
  logic [CNW-1:0]       m_dec;

  always_comb begin
    w_ext     = CW'(window) << FRAC_BITS;
    wf_sum    = w_ext + CW'(frac);
    loss_half = wf_sum >> 1;
    ssth_ext  = CW'(cfg_data[SSTH_W-1:0]) << FRAC_BITS;
    esum      = (26'(est) << 3) - 26'(est) + 26'(c_smp);
    est_new   = sat22(25'(esum >> 3));
    smp22     = Q_W'(c_smp);
    diff      = (smp22 > est) ? (smp22 - est) : (est - smp22);
    dsum      = (25'(dev) << 1) + 25'(dev) + 25'({diff[Q_W-1:4], 4'b0000});
    dev_new   = sat22(dsum >> 2);
    tmo_short = sat22(25'(est) + 25'(dev));
    tmo_long  = sat22(25'(est) + (25'(dev) << 2));
    tmo_dev   = sat22(25'(est) + 25'(dev_new));
    rem_sh    = {rem, (dcnt == '0)};
    fsum      = (FRAC_BITS+2)'(frac) + (FRAC_BITS+2)'(q);
    dup_inc   = (dup_count == {DUP_W{1'b1}}) ? dup_count : dup_count + 1'b1;
    k_inc     = k + 1'b1;
    m_dec     = m - 1'b1;
  end

  assign cmd.ready = (state == S_IDLE);
  assign res.valid = res_valid;
  assign res.data  = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_rtt     <= RST_INIT_RTT;
      cfg_ssth    <= RST_INIT_SSTH;
      cfg_fin     <= RST_FIN_ROUNDS;
      cfg_dup     <= RST_DUP_LIMIT;
      state       <= S_IDLE;
      slot_valid  <= '0;
      cnt         <= '0;
      window      <= WIN_W'(1);
      frac        <= '0;
      thr         <= CW'(RST_INIT_SSTH) << FRAC_BITS;
      outstanding <= '0;
      last_ack    <= '0;
      dup_count   <= '0;
      fresh       <= 1'b0;
      idle_rounds <= '0;
      est         <= Q_W'(RST_INIT_RTT);
      dev         <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (res_valid && res.ready) res_valid <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_INIT_RTT: begin
            cfg_rtt <= cfg_data[RTT_W-1:0];
            est     <= Q_W'(cfg_data[RTT_W-1:0]);
          end
          REG_INIT_SSTH: begin
            cfg_ssth <= cfg_data[SSTH_W-1:0];
            thr      <= (ssth_ext > CW'(MASK22)) ? CW'(MASK22) : ssth_ext;
          end
          REG_FIN_ROUNDS: cfg_fin <= cfg_data[FINR_W-1:0];
          REG_DUP_LIMIT:  cfg_dup <= cfg_data[DUP_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            c_cmd   <= cmd.data.command;
            c_seq   <= cmd.data.new_seqno;
            c_ack   <= cmd.data.ack_number;
            c_fin   <= cmd.data.final_ack;
            c_smp   <= cmd.data.rtt_sample_q4;
            c_newer <= cmd.data.ack_number > last_ack;
            o       <= '0;
            i       <= '0;
            case (cmd.data.command)
              CMD_SEND: begin
                if (outstanding < window) begin
                  state <= S_SCAN;
                end else begin
                  o.send_refused <= 1'b1;
                  state <= S_FIN;
                end
              end
              CMD_ACK: begin
                state <= (cmd.data.ack_number > last_ack) ? S_EST : S_RCHK;
              end
              CMD_TIMEOUT: state <= S_LSTART;
              default: state <= S_FIN;
            endcase
          end
        end

        // first free slot inside the window
        S_SCAN: begin
          if (i < window) begin
            if (!slot_valid[i[SIW-1:0]]) state <= S_SEND;
            else i <= i + 1'b1;
          end else begin
            o.send_refused <= 1'b1;
            state <= S_FIN;
          end
        end

        S_SEND: begin
          if (cnt != '0) begin
            cache_rd <= cache_mem[0];
            state    <= S_POPWR;
          end else begin
            slot_mem[i[SIW-1:0]]   <= c_seq;
            slot_valid[i[SIW-1:0]] <= 1'b1;
            outstanding  <= outstanding + 1'b1;
            o.send_seqno <= c_seq;
            if (outstanding == '0) begin
              o.timer_restart <= 1'b1;
              o.timeout_q4    <= tmo_long;
            end
            state <= S_FIN;
          end
        end

        S_POPWR: begin
          slot_mem[i[SIW-1:0]]   <= cache_rd;
          slot_valid[i[SIW-1:0]] <= 1'b1;
          outstanding  <= outstanding + 1'b1;
          o.send_seqno <= cache_rd;
          o.from_cache <= 1'b1;
          if (outstanding == '0) begin
            o.timer_restart <= 1'b1;
            o.timeout_q4    <= tmo_long;
          end
          k     <= '0;
          state <= S_SHRD;
        end

        // pull the cache down by one entry
        S_SHRD: begin
          if (k_inc < cnt) begin
            cache_rd <= cache_mem[k_inc[CIW-1:0]];
            state    <= S_SHWR;
          end else begin
            cnt   <= cnt - 1'b1;
            state <= S_FIN;
          end
        end

        S_SHWR: begin
          cache_mem[k[CIW-1:0]] <= cache_rd;
          k     <= k_inc;
          state <= S_SHRD;
        end

        S_EST: begin
          est   <= est_new;
          state <= S_DEV;
        end

        S_DEV: begin
          dev         <= dev_new;
          fresh       <= 1'b1;
          idle_rounds <= '0;
          if (outstanding != '0) begin
            o.timer_restart <= 1'b1;
            o.timeout_q4    <= tmo_dev;
          end
          state <= S_RCHK;
        end

        // remove acked slots; window may grow while walking
        S_RCHK: begin
          if (i < window) begin
            if (slot_valid[i[SIW-1:0]]) begin
              slot_rd <= slot_mem[i[SIW-1:0]];
              state   <= S_RCMP;
            end else begin
              i <= i + 1'b1;
            end
          end else begin
            state <= S_POSTACK;
          end
        end

        S_RCMP: begin
          if (slot_rd < c_ack) begin
            slot_valid[i[SIW-1:0]] <= 1'b0;
            if (outstanding != '0) outstanding <= outstanding - 1'b1;
            state <= S_GROW;
          end else begin
            i     <= i + 1'b1;
            state <= S_RCHK;
          end
        end

        S_GROW: begin
          if (w_ext < thr) begin
            if (window < WIN_W'(SLOTS)) window <= window + 1'b1;
            i     <= i + 1'b1;
            state <= S_RCHK;
          end else begin
            den   <= DW'(wf_sum);
            rem   <= '0;
            q     <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end

        // restoring divide of 2^(2F) by den, one bit per cycle
        S_DIV: begin
          if (rem_sh >= {1'b0, den}) begin
            rem <= DW'(rem_sh - {1'b0, den});
            q   <= {q[FRAC_BITS-1:0], 1'b1};
          end else begin
            rem <= rem_sh[DW-1:0];
            q   <= {q[FRAC_BITS-1:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == DIV_LAST) state <= S_GFIN;
        end

        S_GFIN: begin
          if (fsum > ONE) begin
            frac <= FW'(fsum - ONE);
            if (window < WIN_W'(SLOTS)) window <= window + 1'b1;
          end else begin
            frac <= FW'(fsum);
          end
          i     <= i + 1'b1;
          state <= S_RCHK;
        end

        S_POSTACK: begin
          if (c_newer) begin
            last_ack  <= c_ack;
            dup_count <= '0;
            state     <= S_FIN;
          end else begin
            dup_count <= dup_inc;
            if (dup_inc >= cfg_dup && fresh) begin
              fresh <= 1'b0;
              state <= S_LSTART;
            end else begin
              state <= S_FIN;
            end
          end
        end

        S_LSTART: begin
          if (idle_rounds != {FINR_W{1'b1}}) idle_rounds <= idle_rounds + 1'b1;
          if (window >= WIN_W'(4))
            thr <= (loss_half > CW'(MASK22)) ? CW'(MASK22) : loss_half;
          else
            thr <= CW'(2) << FRAC_BITS;
          n_sorted  <= '0;
          have_last <= 1'b0;
          have_min  <= 1'b0;
          j         <= '0;
          state     <= S_SRT;
        end

        // sorted, duplicate-free copy: next minimum above the last one taken
        S_SRT: begin
          if (j < WIN_W'(SLOTS)) begin
            if (slot_valid[j[SIW-1:0]]) begin
              slot_rd <= slot_mem[j[SIW-1:0]];
              state   <= S_SRTCMP;
            end else begin
              j <= j + 1'b1;
            end
          end else begin
            state <= S_SRTEND;
          end
        end

        S_SRTCMP: begin
          if ((!have_last || slot_rd > last_v) && (!have_min || slot_rd < mn)) begin
            mn       <= slot_rd;
            have_min <= 1'b1;
          end
          j     <= j + 1'b1;
          state <= S_SRT;
        end

        S_SRTEND: begin
          if (have_min) begin
            tmp_mem[n_sorted[SIW-1:0]] <= mn;
            n_sorted  <= n_sorted + 1'b1;
            last_v    <= mn;
            have_last <= 1'b1;
            have_min  <= 1'b0;
            j         <= '0;
            state     <= S_SRT;
          end else begin
            i     <= '0;
            state <= S_WBCHK;
          end
        end

        S_WBCHK: begin
          if (i < WIN_W'(SLOTS)) begin
            if (i < n_sorted) begin
              tmp_rd <= tmp_mem[i[SIW-1:0]];
              state  <= S_WBUSE;
            end else begin
              slot_valid[i[SIW-1:0]] <= 1'b0;
              i <= i + 1'b1;
            end
          end else begin
            state <= S_LEND;
          end
        end

        S_WBUSE: begin
          if (i != '0 && i < window) begin
            k     <= '0;
            state <= S_CSCAN;
          end else begin
            if (i == '0) begin
              o.retransmit       <= 1'b1;
              o.retransmit_seqno <= tmp_rd;
            end
            slot_mem[i[SIW-1:0]]   <= tmp_rd;
            slot_valid[i[SIW-1:0]] <= 1'b1;
            i     <= i + 1'b1;
            state <= S_WBCHK;
          end
        end

        // sorted insert of tmp_rd into the cache; a duplicate is dropped, and with the cache full it stays in its slot
        S_CSCAN: begin
          if (k < cnt) begin
            cache_rd <= cache_mem[k[CIW-1:0]];
            state    <= S_CCMP;
          end else if (cnt >= CNW'(CACHE_SLOTS)) begin
            slot_mem[i[SIW-1:0]]   <= tmp_rd;
            slot_valid[i[SIW-1:0]] <= 1'b1;
            i     <= i + 1'b1;
            state <= S_WBCHK;
          end else begin
            m     <= cnt;
            state <= S_CSHRD;
          end
        end

        S_CCMP: begin
          if (cache_rd < tmp_rd) begin
            k     <= k_inc;
            state <= S_CSCAN;
          end else if (cache_rd == tmp_rd) begin
            slot_valid[i[SIW-1:0]] <= 1'b0;
            if (outstanding != '0) outstanding <= outstanding - 1'b1;
            i     <= i + 1'b1;
            state <= S_WBCHK;
          end else if (cnt >= CNW'(CACHE_SLOTS)) begin
            slot_mem[i[SIW-1:0]]   <= tmp_rd;
            slot_valid[i[SIW-1:0]] <= 1'b1;
            i     <= i + 1'b1;
            state <= S_WBCHK;
          end else begin
            m     <= cnt;
            state <= S_CSHRD;
          end
        end

        S_CSHRD: begin
          if (m > k) begin
            cache_rd <= cache_mem[m_dec[CIW-1:0]];
            state    <= S_CSHWR;
          end else begin
            cache_mem[k[CIW-1:0]] <= tmp_rd;
            cnt <= cnt + 1'b1;
            slot_valid[i[SIW-1:0]] <= 1'b0;
            if (outstanding != '0) outstanding <= outstanding - 1'b1;
            i     <= i + 1'b1;
            state <= S_WBCHK;
          end
        end

        S_CSHWR: begin
          cache_mem[m[CIW-1:0]] <= cache_rd;
          m     <= m_dec;
          state <= S_CSHRD;
        end

        S_LEND: begin
          window          <= WIN_W'(1);
          frac            <= '0;
          o.timer_restart <= 1'b1;
          o.timeout_q4    <= tmo_short;
          if (c_cmd == CMD_ACK) dup_count <= '0;
          state <= S_FIN;
        end

        S_FIN: begin
          if (!res_valid || res.ready) begin
            res_q.cwnd_size        <= CNT_W'(window);
            res_q.ssthresh_q16     <= thr[Q_W-1:0];
            res_q.in_flight        <= CNT_W'(outstanding);
            res_q.send_seqno       <= o.send_seqno;
            res_q.from_cache       <= o.from_cache;
            res_q.send_refused     <= o.send_refused;
            res_q.cache_count      <= CNT_W'(cnt);
            res_q.retransmit       <= o.retransmit;
            res_q.retransmit_seqno <= o.retransmit_seqno;
            res_q.timer_restart    <= o.timer_restart;
            res_q.timeout_q4       <= o.timeout_q4;
            res_q.finished         <= (c_cmd == CMD_ACK && c_fin) ||
                                      (idle_rounds >= cfg_fin);
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sim/tcwc_checker.sv
// Scoreboard for the TCP congestion window controller: watches the command,
// result and register write ports, predicts each result and compares it.
// Depends on tcwc_pkg and tcwc_if.
`timescale 1ns / 1ps
`default_nettype none
module tcwc_checker
  import tcwc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  tcwc_cmd_if                       cmd_mon,
  tcwc_res_if                       res_mon,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        fail_count,
  output int                        pending
);

  localparam int NSLOT  = 64;
  localparam int NCACHE = 64;
  localparam int FB     = 16;

  // register copies
  logic [RTT_W-1:0]  cfg_rtt;
  logic [SSTH_W-1:0] cfg_ssth;
  logic [FINR_W-1:0] cfg_fin;
  logic [DUP_W-1:0]  cfg_dup;

  // window controller state
  logic [SEQ_W-1:0] slot_num [NSLOT];
  bit               slot_used [NSLOT];
  logic [SEQ_W-1:0] resend_q [$];
  int unsigned      cwnd;
  longint unsigned  cwnd_frac;
  longint unsigned  thresh;
  int unsigned      unacked;
  logic [SEQ_W-1:0] high_ack;
  int unsigned      dups;
  bit               new_ack_seen;
  int unsigned      dead_rounds;
  longint unsigned  srtt;
  longint unsigned  rttvar;

  res_item_t expected_results [$];
  int        mismatches;

  function automatic longint unsigned clip22(longint unsigned v);
    return (v > longint'(MASK22)) ? longint'(MASK22) : v;
  endfunction

  function automatic void open_window();
    longint unsigned one, w;
    one = 64'd1 << FB;
    w   = longint'(cwnd) << FB;
    if (w < thresh) begin
      if (cwnd < NSLOT) cwnd++;
    end else begin
      cwnd_frac += (one * one) / (w + cwnd_frac);
      if (cwnd_frac > one) begin
        cwnd_frac -= one;
        if (cwnd < NSLOT) cwnd++;
      end
    end
  endfunction

  function automatic void drop_acked(logic [SEQ_W-1:0] ackno);
    // loop bound tracks the window as it grows
    for (int i = 0; i < cwnd && i < NSLOT; i++) begin
      if (slot_used[i] && slot_num[i] < ackno) begin
        slot_used[i] = 0;
        if (unacked > 0) unacked--;
        open_window();
      end
    end
  endfunction

  function automatic bit cache_add(logic [SEQ_W-1:0] v);
    int p;
    p = 0;
    while (p < resend_q.size() && resend_q[p] < v) p++;
    if (p < resend_q.size() && resend_q[p] == v) return 1;
    if (resend_q.size() >= NCACHE) return 0;
    resend_q.insert(p, v);
    return 1;
  endfunction

  function automatic void take_loss(ref res_item_t r);
    logic [SEQ_W-1:0] vals [$];
    if (dead_rounds < 511) dead_rounds++;
    if (cwnd >= 4) thresh = ((longint'(cwnd) << FB) + cwnd_frac) >> 1;
    else thresh = 64'd2 << FB;
    thresh = clip22(thresh);
    // sort slot table ascending, merging duplicates
    for (int i = 0; i < NSLOT; i++)
      if (slot_used[i]) vals.push_back(slot_num[i]);
    vals.sort();
    for (int i = vals.size() - 1; i > 0; i--)
      if (vals[i] == vals[i-1]) vals.delete(i);
    for (int i = 0; i < NSLOT; i++) begin
      slot_used[i] = i < vals.size();
      slot_num[i]  = (i < vals.size()) ? vals[i] : '0;
    end
    for (int i = 1; i < cwnd && i < NSLOT; i++) begin
      if (slot_used[i] && cache_add(slot_num[i])) begin
        slot_used[i] = 0;
        if (unacked > 0) unacked--;
      end
    end
    cwnd = 1;
    cwnd_frac = 0;
    if (slot_used[0]) begin
      r.retransmit = 1;
      r.retransmit_seqno = slot_num[0];
    end
    r.timer_restart = 1;
    r.timeout_q4 = Q_W'(clip22(srtt + rttvar));
  endfunction

  function automatic res_item_t predict_window(cmd_item_t c);
    res_item_t r;
    int free_idx;
    logic [SEQ_W-1:0] v;
    longint unsigned d;
    r = '0;
    case (c.command)
      CMD_SEND: begin
        free_idx = -1;
        if (unacked < cwnd)
          for (int i = 0; i < cwnd && i < NSLOT; i++)
            if (!slot_used[i]) begin
              free_idx = i;
              break;
            end
        if (free_idx < 0) begin
          r.send_refused = 1;
        end else begin
          v = c.new_seqno;
          if (resend_q.size() > 0) begin
            v = resend_q.pop_front();
            r.from_cache = 1;
          end
          slot_num[free_idx] = v;
          slot_used[free_idx] = 1;
          unacked++;
          r.send_seqno = v;
          if (unacked == 1) begin
            r.timer_restart = 1;
            r.timeout_q4 = Q_W'(clip22(srtt + 4 * rttvar));
          end
        end
      end
      CMD_ACK: begin
        if (c.ack_number > high_ack) begin
          srtt = clip22((7 * srtt + c.rtt_sample_q4) >> 3);
          d = (c.rtt_sample_q4 > srtt) ? c.rtt_sample_q4 - srtt : srtt - c.rtt_sample_q4;
          d = (d >> 4) << 4;
          rttvar = clip22((3 * rttvar + d) >> 2);
          new_ack_seen = 1;
          dead_rounds = 0;
          if (unacked > 0) begin
            r.timer_restart = 1;
            r.timeout_q4 = Q_W'(clip22(srtt + rttvar));
          end
          drop_acked(c.ack_number);
          high_ack = c.ack_number;
          dups = 0;
        end else begin
          drop_acked(c.ack_number);
          if (dups < 7) dups++;
          if (dups >= cfg_dup && new_ack_seen) begin
            new_ack_seen = 0;
            take_loss(r);
            dups = 0;
          end
        end
      end
      CMD_TIMEOUT: take_loss(r);
      default: ;
    endcase
    r.cwnd_size    = CNT_W'(cwnd);
    r.ssthresh_q16 = Q_W'(thresh);
    r.in_flight    = CNT_W'(unacked);
    r.cache_count  = CNT_W'(resend_q.size());
    r.finished     = (c.command == CMD_ACK && c.final_ack) || dead_rounds >= cfg_fin;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v,
                                      ref bit bad);
    if (exp_v !== act_v) begin
      bad = 1;
      if (mismatches < 10)
        $display("[%0t] mismatch %s: expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    res_item_t e, a;
    bit bad;
    if (rst) begin
      cfg_rtt = RST_INIT_RTT;
      cfg_ssth = RST_INIT_SSTH;
      cfg_fin = RST_FIN_ROUNDS;
      cfg_dup = RST_DUP_LIMIT;
      for (int i = 0; i < NSLOT; i++) begin
        slot_used[i] = 0;
        slot_num[i] = '0;
      end
      resend_q.delete();
      cwnd = 1;
      cwnd_frac = 0;
      // not saturated after reset; only the low 22 bits are reported
      thresh = longint'(RST_INIT_SSTH) << FB;
      unacked = 0;
      high_ack = '0;
      dups = 0;
      new_ack_seen = 0;
      dead_rounds = 0;
      srtt = RST_INIT_RTT;
      rttvar = 0;
      expected_results.delete();
      fail_count = 0;
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INIT_RTT: begin
            cfg_rtt = cfg_data[RTT_W-1:0];
            srtt = cfg_rtt;
          end
          REG_INIT_SSTH: begin
            cfg_ssth = cfg_data[SSTH_W-1:0];
            thresh = clip22(longint'(cfg_ssth) << FB);
          end
          REG_FIN_ROUNDS: cfg_fin = cfg_data[FINR_W-1:0];
          REG_DUP_LIMIT: cfg_dup = cfg_data[DUP_W-1:0];
          default: ;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        a = res_mon.data;
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("[%0t] result item with nothing expected", $time);
          mismatches++;
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          bad = 0;
          check_field("cwnd_size", e.cwnd_size, a.cwnd_size, bad);
          check_field("ssthresh_q16", e.ssthresh_q16, a.ssthresh_q16, bad);
          check_field("in_flight", e.in_flight, a.in_flight, bad);
          check_field("send_seqno", e.send_seqno, a.send_seqno, bad);
          check_field("from_cache", e.from_cache, a.from_cache, bad);
          check_field("send_refused", e.send_refused, a.send_refused, bad);
          check_field("cache_count", e.cache_count, a.cache_count, bad);
          check_field("retransmit", e.retransmit, a.retransmit, bad);
          check_field("retransmit_seqno", e.retransmit_seqno, a.retransmit_seqno, bad);
          check_field("timer_restart", e.timer_restart, a.timer_restart, bad);
          check_field("timeout_q4", e.timeout_q4, a.timeout_q4, bad);
          check_field("finished", e.finished, a.finished, bad);
          if (bad) begin
            mismatches++;
            fail_count++;
          end
        end
      end
      if (cmd_mon.valid && cmd_mon.ready)
        expected_results.push_back(predict_window(cmd_mon.data));
    end
    pending = expected_results.size();
  end

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Top of the TCP congestion window controller testbench: clock, reset,
// register phases, command stimulus, result stalls and the verdict.
// Depends on tcwc_pkg, tcwc_if, tcwc_checker and the controller RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import tcwc_pkg::*;

  localparam int IDLE_LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int fail_count, pending;
  int idle_cycles = 0;
  int n_send = 0, n_ack = 0, n_tmo = 0, n_other = 0, n_phase = 0;
  int unsigned stall_mode = 0, stall_timer = 0;
  logic [SEQ_W-1:0] next_seq, ack_base;

  tcwc_cmd_if cmd_ch();
  tcwc_res_if res_ch();

  always #6 clk = ~clk;

  tcp_congestion_window_controller i_dut (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .res(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tcwc_checker i_checker (
    .clk(clk), .rst(rst), .cmd_mon(cmd_ch), .res_mon(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    cmd_ch.valid = 0;
    cmd_ch.data = '0;
    res_ch.ready = 0;
  end

  // receiver: modes of no stall, light random stall and long stalls
  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_timer <= $urandom_range(50, 300);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= ($urandom_range(0, 3) != 0);
      default: res_ch.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge where the item was taken
  task automatic put_item(cmd_item_t it);
    logic r;
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= it;
    case (it.command)
      CMD_SEND: n_send++;
      CMD_ACK: n_ack++;
      CMD_TIMEOUT: n_tmo++;
      default: n_other++;
    endcase
    forever begin
      @(negedge clk);
      r = cmd_ch.ready;
      @(posedge clk);
      if (r) break;
    end
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(int rtt, int ssth, int fin, int dup);
    drain();
    write_reg(REG_INIT_RTT, CFG_W'(rtt));
    write_reg(REG_INIT_SSTH, CFG_W'(ssth));
    write_reg(REG_FIN_ROUNDS, CFG_W'(fin));
    write_reg(REG_DUP_LIMIT, CFG_W'(dup));
    n_phase++;
  endtask

  function automatic cmd_item_t mk(logic [1:0] c, logic [31:0] s, logic [31:0] a,
                                   logic f, logic [19:0] rtt);
    cmd_item_t it;
    it.command = c;
    it.new_seqno = s;
    it.ack_number = a;
    it.final_ack = f;
    it.rtt_sample_q4 = rtt;
    return it;
  endfunction

  // mostly well-formed traffic: rising sequence numbers, advancing or repeated acks
  function automatic cmd_item_t flow_item();
    int unsigned r;
    logic [19:0] rtt;
    cmd_item_t it;
    r = $urandom_range(0, 99);
    rtt = ($urandom_range(0, 19) == 0) ? 20'($urandom) : 20'($urandom_range(800, 4000));
    if (r < 45) begin
      it = mk(CMD_SEND, next_seq, 32'($urandom), 0, rtt);
      next_seq += 1000;
    end else if (r < 85) begin
      if ($urandom_range(0, 9) < 6) begin
        ack_base += $urandom_range(1, 3) * 1000;
        if (ack_base > next_seq) next_seq = ack_base;
      end
      it = mk(CMD_ACK, 32'($urandom), ack_base + 1, ($urandom_range(0, 32) == 0), rtt);
    end else if (r < 92) begin
      it = mk(CMD_TIMEOUT, 32'($urandom), 32'($urandom), 1'($urandom), rtt);
    end else begin
      it = mk(2'($urandom), 32'($urandom), 32'($urandom_range(0, ack_base)),
              1'($urandom), 20'($urandom));
    end
    return it;
  endfunction

  task automatic flow_phase(int count);
    int left;
    left = count;
    while (left > 0) begin
      for (int b = $urandom_range(1, 30); b > 0 && left > 0; b--) begin
        put_item(flow_item());
        left--;
      end
      pause_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25));
    end
  endtask

  initial begin
    next_seq = 32'd1000;
    ack_base = 32'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, each command, empty-table loss, fast retransmit
    put_item(mk(CMD_TIMEOUT, 0, 0, 0, 0));                  // loss with nothing outstanding
    put_item(mk(CMD_ACK, 0, 0, 1, 20'hFFFFF));              // duplicate of zero, final flag
    put_item(mk(CMD_SEND, 32'd0, 0, 0, 0));
    put_item(mk(CMD_SEND, 32'hFFFF_FFFF, 0, 0, 0));         // refused: window is one
    put_item(mk(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 20'hFFFFF));
    put_item(mk(CMD_ACK, 0, 32'd10, 0, 20'd0));             // new ack, zero sample
    put_item(mk(CMD_SEND, 32'd100, 0, 0, 0));
    put_item(mk(CMD_ACK, 0, 32'd200, 0, 20'hFFFFF));        // largest sample
    put_item(mk(CMD_SEND, 32'd300, 0, 0, 0));
    put_item(mk(CMD_SEND, 32'd400, 0, 0, 0));
    put_item(mk(CMD_SEND, 32'd500, 0, 0, 0));
    put_item(mk(CMD_ACK, 0, 32'd200, 0, 0));                // duplicates up to the limit
    put_item(mk(CMD_ACK, 0, 32'd200, 0, 0));
    put_item(mk(CMD_ACK, 0, 32'd200, 0, 0));
    put_item(mk(CMD_SEND, 32'd600, 0, 0, 0));               // refused: window is one after the loss
    put_item(mk(CMD_SEND, 32'd700, 0, 0, 0));
    put_item(mk(CMD_TIMEOUT, 0, 0, 0, 0));
    put_item(mk(CMD_SEND, 32'd800, 0, 0, 0));
    put_item(mk(CMD_ACK, 0, 32'd1000, 1, 20'd1500));
    next_seq = 32'd2000;
    ack_base = 32'd1000;

    flow_phase(200);
    set_regs(0, 2, 1, 1);                  // low extremes, finish after one loss
    flow_phase(200);
    set_regs(1048575, 64, 511, 7);         // high extremes
    flow_phase(350);
    set_regs(16, 8, 3, 2);
    flow_phase(200);
    set_regs(3000, 4, 100, 3);
    flow_phase(200);
    set_regs(500, 16, 5, 3);
    // noise over full field ranges, acks may jump to the top of the space
    for (int i = 0; i < 80; i++) begin
      put_item(mk(2'($urandom_range(0, 3)), 32'($urandom), 32'($urandom),
                  1'($urandom), 20'($urandom)));
      pause_sender($urandom_range(0, 1) * $urandom_range(1, 10));
    end
    put_item(mk(CMD_ACK, 0, 32'hFFFF_FFFF, 0, 20'd100));

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d sends, %0d acks, %0d timeouts, %0d other commands",
             n_send, n_ack, n_tmo, n_other);
    $display("across %0d register settings after reset defaults, %0d failures",
             n_phase, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
